// ----- src/calibration_table_interpolator_top_macros.svh -----
// Assertion macros for the calibration table interpolator.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_TOP_MACROS_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/cti_pkg.sv -----
// Package with the types and constants of the calibration table interpolator.
`default_nettype none
package cti_pkg;
  localparam int MaxPoints  = 32;
  localparam int NumTables  = 4;
  localparam int IdxW       = $clog2(MaxPoints);
  localparam int TblW       = 2;
  localparam int AddrW      = $clog2(MaxPoints * NumTables);
  localparam int CntW       = 6;
  localparam int QW         = 3;

  localparam logic OpLoad   = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  table_select;
    logic [4:0]  point_index;
    logic [31:0] point_frequency;
    logic [7:0]  point_attenuation;
    logic [31:0] query_frequency;
  } in_item_t;

  typedef struct packed {
    logic [5:0] attenuation;
    logic       inside_table;
  } out_item_t;

  typedef struct packed {
    logic        opcode;
    logic        valid_table;
    logic [AddrW-1:0] base;
    logic [IdxW-1:0]  index;
    logic [CntW-1:0]  count;
    logic [31:0] freq;
    logic [7:0]  att;
  } cmd_t;
endpackage
`default_nettype wire

// ----- src/cti_front.sv -----
// Front part: accepts items, resolves table base and used count, fills the queue.
`default_nettype none
module cti_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [5:0]       cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cti_pkg::in_item_t in_data_i,
  output logic                  cmd_valid_o,
  input  wire logic             cmd_ready_i,
  output cti_pkg::cmd_t         cmd_o
);
  import cti_pkg::*;
  localparam int Depth = 2 ** QW;
  logic [CntW-1:0] cnt_q [NumTables];
  cmd_t            fifo_q [Depth];
  logic [QW-1:0]   wp_q, rp_q;
  logic [QW:0]     fill_q;
  cmd_t            cmd_d;
  logic [CntW-1:0] c;
  logic            push, pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (fill_q != (QW+1)'(Depth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rp_q];

  always_comb begin
    c = cnt_q[in_data_i.table_select];
    cmd_d.opcode      = in_data_i.opcode;
    cmd_d.valid_table = (32'(in_data_i.table_select) < NumTables);
    cmd_d.base        = AddrW'(in_data_i.table_select) << IdxW;
    cmd_d.index       = IdxW'(in_data_i.point_index);
    cmd_d.count       = (c > CntW'(MaxPoints)) ? CntW'(MaxPoints) : c;
    cmd_d.freq        = (in_data_i.opcode == OpLoad) ? in_data_i.point_frequency
                                                     : in_data_i.query_frequency;
    cmd_d.att         = in_data_i.point_attenuation;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTables; i++) cnt_q[i] <= '0;
      wp_q <= '0; rp_q <= '0; fill_q <= '0;
    end else begin
      if (cfg_valid_i) cnt_q[cfg_index_i] <= cfg_data_i;
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      fill_q <= fill_q + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_d;
  end
endmodule
`default_nettype wire

// ----- src/cti_div.sv -----
// Restoring serial divider with rounding-half-up quotient of num by den.
`default_nettype none
module cti_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [40:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [5:0]       quo_o
);
  logic [41:0] rem_q;
  logic [42:0] den_q;
  logic [6:0]  quo_q;
  logic [2:0]  cnt_q;
  logic        busy_q;

  assign quo_o  = quo_q[6:1] + 6'(quo_q[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_o <= 1'b0; cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; cnt_q <= 3'd6;
      end else if (busy_q) begin
        if (cnt_q == 3'd0) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {num_i, 1'b0};
      den_q <= {4'b0, den_i, 6'b0};
      quo_q <= '0;
    end else if (busy_q) begin
      if ({1'b0, rem_q} >= den_q) begin
        rem_q <= 42'({1'b0, rem_q} - den_q);
        quo_q[cnt_q] <= 1'b1;
      end
      den_q <= den_q >> 1;
    end
  end
endmodule
`default_nettype wire

// ----- src/cti_back.sv -----
// Back part: table storage, serial search, interpolation and output register.
`default_nettype none
module cti_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire cti_pkg::cmd_t     cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cti_pkg::out_item_t     out_data_o
);
  import cti_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_RD0, S_LD0, S_MUL, S_SUM, S_GO, S_DIV, S_OUT
  } state_e;
  state_e state_q;
  logic [31:0] fmem [MaxPoints*NumTables];
  logic [7:0]  amem [MaxPoints*NumTables];
  logic [31:0] frd_q, f1_q, f0_q;
  logic [7:0]  ard_q, a1_q, a0_q;
  logic [AddrW-1:0] raddr_q;
  logic [CntW-1:0] pos_q;
  cmd_t        c_q;
  logic [32:0] df_q;
  logic [40:0] p0_q;
  logic signed [41:0] p1_q;
  logic signed [42:0] sum_q;
  logic [40:0] div_num;
  logic        att_big, div_start, div_done;
  logic [5:0]  quo;
  logic        wr;

  assign cmd_ready_o = (state_q == S_IDLE) && !out_valid_o;
  assign wr = cmd_valid_i && cmd_ready_o && cmd_i.opcode == OpLoad && cmd_i.valid_table
              && 32'(cmd_i.index) < MaxPoints;
  assign div_start = (state_q == S_GO);

  cti_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(df_q), .done_o(div_done), .quo_o(quo));

  always_ff @(posedge clk_i) begin
    if (wr) begin
      fmem[cmd_i.base | AddrW'(cmd_i.index)] <= cmd_i.freq;
      amem[cmd_i.base | AddrW'(cmd_i.index)] <= cmd_i.att;
    end
    frd_q <= fmem[raddr_q];
    ard_q <= amem[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; out_valid_o <= 1'b0; out_data_o <= '0;
      pos_q <= '0; raddr_q <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o && cmd_i.opcode == OpLookup) begin
            c_q <= cmd_i; pos_q <= '0; raddr_q <= cmd_i.base;
            if (!cmd_i.valid_table || cmd_i.count < CntW'(2)) begin
              out_data_o <= '0; out_valid_o <= 1'b1;
            end else state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (frd_q > c_q.freq) begin
            f1_q <= frd_q; a1_q <= ard_q;
            if (pos_q == '0) begin
              out_data_o <= '0; out_valid_o <= 1'b1; state_q <= S_IDLE;
            end else begin
              raddr_q <= raddr_q - 1'b1; state_q <= S_RD0;
            end
          end else if (pos_q + 1'b1 >= c_q.count) begin
            out_data_o <= '0; out_valid_o <= 1'b1; state_q <= S_IDLE;
          end else begin
            pos_q <= pos_q + 1'b1; raddr_q <= raddr_q + 1'b1; state_q <= S_RD;
          end
        end
        S_RD0: state_q <= S_LD0;
        S_LD0: begin
          f0_q <= frd_q; a0_q <= ard_q;
          df_q <= {1'b0, f1_q} - {1'b0, frd_q};
          state_q <= S_MUL;
        end
        S_MUL: begin
          p0_q <= 41'(a0_q) * 41'(df_q);
          p1_q <= $signed({1'b0, c_q.freq - f0_q}) * $signed({1'b0, a1_q} - {1'b0, a0_q});
          state_q <= S_SUM;
        end
        S_SUM: begin
          sum_q <= 43'($signed({1'b0, p0_q})) + 43'(p1_q);
          state_q <= S_GO;
        end
        S_GO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) state_q <= S_OUT;
        end
        default: begin
          out_data_o.inside_table <= 1'b1;
          out_data_o.attenuation <= att_big ? 6'd63 : quo;
          out_valid_o <= 1'b1; state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    div_num = sum_q[42] ? '0 : sum_q[40:0];
    att_big = !sum_q[42] && ({2'b0, sum_q[40:0]} > 43'(df_q) * 43'd63);
  end
endmodule
`default_nettype wire

// ----- src/calibration_table_interpolator_top.sv -----
// A load is written when the back end takes it; a lookup scans points, then multiplies, sums and divides.
// The serial table scan, which reads and then compares one point at a time, sets the rate.
// One item is in the back end at a time; an 8-entry queue buffers the front.
// Reset clears counts, queue and control; table contents stay undefined until loaded.
// Attenuation is computed by multiply then a 7-step restoring divide.
`default_nettype none
`include "calibration_table_interpolator_top_macros.svh"
module calibration_table_interpolator_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [5:0]          cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire cti_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output cti_pkg::out_item_t       out_data_o
);
  import cti_pkg::*;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  cti_front u_front (.clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i, .in_valid_i, .in_ready_o, .in_data_i, .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready), .cmd_o(cmd));
  cti_back u_back (.clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid_o, .out_ready_i, .out_data_o);

  `CTI_ASSERT_IMP(a_att_zero_out, clk_i, rst_ni,
    out_valid_o && !out_data_o.inside_table, out_data_o.attenuation == 6'd0)
  `CTI_ASSERT_IMP(a_no_take_busy, clk_i, rst_ni, out_valid_o, !cmd_ready)
endmodule
`default_nettype wire

// ----- tb/calibration_table_interpolator_top_test.sv -----
// Testbench for the calibration table interpolator: loads, lookups and count settings checked.
module calibration_table_interpolator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cti_pkg::*;

  typedef enum logic [1:0] {
    RegReceive = 2'd0, RegTransmit = 2'd1, RegVoltage = 2'd2, RegCurrent = 2'd3
  } cnt_reg_e;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  bit in_taken = 1'b0;

  calibration_table_interpolator_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [31:0] freq_mirror [NumTables][MaxPoints];
  logic [7:0] att_mirror [NumTables][MaxPoints];
  bit written [NumTables][MaxPoints];
  logic [5:0] used_points [NumTables];

  in_item_t pending_items[$];
  out_item_t expected_atts[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_sender = 1'b0;

  function automatic out_item_t interpolate(input int tbl, input logic [31:0] q);
    out_item_t r;
    int cnt;
    int pos;
    longint f0, f1, a0, a1, df, num;
    r = '0;
    cnt = used_points[tbl] > MaxPoints ? MaxPoints : used_points[tbl];
    for (pos = 0; pos < cnt; pos++) begin
      if (freq_mirror[tbl][pos] > q) break;
    end
    if (pos == 0 || pos >= cnt) return r;
    f0 = freq_mirror[tbl][pos-1];
    f1 = freq_mirror[tbl][pos];
    a0 = att_mirror[tbl][pos-1];
    a1 = att_mirror[tbl][pos];
    df = f1 - f0;
    if (df <= 0) return r;
    num = a0 * df + (longint'(q) - f0) * (a1 - a0);
    if (num < 0) num = 0;
    if (num > 63 * df) r.attenuation = 6'd63;
    else r.attenuation = 6'((2 * num + df) / (2 * df));
    r.inside_table = 1'b1;
    return r;
  endfunction

  // Updates the mirror at acceptance so predictions follow the block's order.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      if (in_data.opcode == OpLoad) begin
        freq_mirror[in_data.table_select][in_data.point_index] <= in_data.point_frequency;
        att_mirror[in_data.table_select][in_data.point_index] <= in_data.point_attenuation;
      end else begin
        expected_atts.push_back(interpolate(in_data.table_select, in_data.query_frequency));
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_atts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        if (out_data !== expected_atts[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected %p actual %p", expected_atts[0], out_data);
        end
        void'(expected_atts.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("calibration_table_interpolator_top: mismatch");
      $finish;
    end
  end

  // Sender in bursts with gaps; the receiver stalls on its own pattern.
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 3) == 0);
      if (!in_valid || in_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!hold_sender && pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic in_item_t make_load(input int tbl, input int idx,
                                         input logic [31:0] f, input logic [7:0] a);
    in_item_t it;
    it = '0;
    it.opcode = OpLoad;
    it.table_select = 2'(tbl);
    it.point_index = 5'(idx);
    it.point_frequency = f;
    it.point_attenuation = a;
    it.query_frequency = $urandom();
    written[tbl][idx] = 1'b1;
    return it;
  endfunction

  function automatic in_item_t make_lookup(input int tbl, input logic [31:0] q);
    in_item_t it;
    it = '0;
    it.opcode = OpLookup;
    it.table_select = 2'(tbl);
    it.query_frequency = q;
    it.point_index = 5'($urandom());
    it.point_frequency = $urandom();
    it.point_attenuation = 8'($urandom());
    return it;
  endfunction

  // Largest count for which every point the scan may touch has been loaded.
  function automatic int safe_count(input int tbl);
    int n;
    n = 0;
    while (n < MaxPoints && written[tbl][n]) n++;
    return n;
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0);
    @(negedge clk);
    while (in_valid || expected_atts.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_count(input cnt_reg_e r, input logic [5:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    used_points[r] = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_counts(input bit extreme);
    int t;
    int lim;
    logic [5:0] v;
    for (t = 0; t < NumTables; t++) begin
      lim = safe_count(t);
      if (extreme) v = ($urandom_range(0, 1) == 0) ? 6'(lim) : 6'(lim < 2 ? lim : 2);
      else v = 6'($urandom_range(0, lim));
      if (lim == MaxPoints && $urandom_range(0, 2) == 0) v = 6'($urandom_range(MaxPoints, 63));
      write_count(cnt_reg_e'(t), v);
    end
  endtask

  // Sorted table load with random spacing, occasionally unsorted or duplicated.
  task automatic load_table(input int tbl, input bit wide);
    int i;
    logic [31:0] f;
    f = wide ? 32'($urandom_range(0, 1000)) : 32'($urandom_range(0, 50));
    for (i = 0; i < MaxPoints; i++) begin
      pending_items.push_back(make_load(tbl, i, f, 8'($urandom())));
      case ($urandom_range(0, 9))
        0: f = f;
        1: f = f - 32'($urandom_range(0, 20));
        default: f = f + (wide ? ($urandom() >> 5) : 32'($urandom_range(1, 40)));
      endcase
    end
  endtask

  function automatic logic [31:0] pick_query(input int tbl);
    int n;
    n = used_points[tbl] > MaxPoints ? MaxPoints : used_points[tbl];
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return n > 0 ? freq_mirror[tbl][$urandom_range(0, n - 1)] : $urandom();
      default: begin
        if (n < 2) return $urandom();
        return freq_mirror[tbl][$urandom_range(0, n - 2)] + 32'($urandom_range(0, 200));
      end
    endcase
  endfunction

  initial begin
    int t, k, phase;
    for (t = 0; t < NumTables; t++) begin
      used_points[t] = '0;
      for (k = 0; k < MaxPoints; k++) written[t][k] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lookups with no used points, then extreme point values.
    for (t = 0; t < NumTables; t++) pending_items.push_back(make_lookup(t, $urandom()));
    pending_items.push_back(make_load(0, 0, 32'h0, 8'hff));
    pending_items.push_back(make_load(0, 1, 32'hffff_ffff, 8'h00));
    pending_items.push_back(make_load(1, 0, 32'd100, 8'h00));
    pending_items.push_back(make_load(1, 1, 32'd200, 8'hff));
    pending_items.push_back(make_load(2, 0, 32'd10, 8'd20));
    pending_items.push_back(make_load(2, 1, 32'd10, 8'd40));
    pending_items.push_back(make_load(3, 31, 32'h5555_aaaa, 8'haa));
    drain();
    write_count(RegReceive, 6'd2);
    write_count(RegTransmit, 6'd2);
    write_count(RegVoltage, 6'd2);
    write_count(RegCurrent, 6'd0);
    pending_items.push_back(make_lookup(0, 32'h0));
    pending_items.push_back(make_lookup(0, 32'h8000_0000));
    pending_items.push_back(make_lookup(0, 32'hffff_fffe));
    pending_items.push_back(make_lookup(0, 32'hffff_ffff));
    pending_items.push_back(make_lookup(1, 32'd99));
    pending_items.push_back(make_lookup(1, 32'd125));
    pending_items.push_back(make_lookup(1, 32'd150));
    pending_items.push_back(make_lookup(1, 32'd199));
    pending_items.push_back(make_lookup(2, 32'd10));
    pending_items.push_back(make_lookup(3, 32'd5));
    drain();

    for (phase = 0; phase < 8; phase++) begin
      for (t = 0; t < NumTables; t++) load_table(t, phase[0]);
      drain();
      set_counts(phase < 2 || phase == 7);
      for (k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          t = $urandom_range(0, NumTables - 1);
          // Rewrite a random point with random values.
          pending_items.push_back(make_load(t, $urandom_range(0, MaxPoints - 1),
              $urandom(), 8'($urandom())));
          pending_items.push_back(make_lookup(t, $urandom()));
        end else begin
          t = $urandom_range(0, NumTables - 1);
          pending_items.push_back(make_lookup(t, pick_query(t)));
        end
        if (k == 50) begin
          wait (pending_items.size() == 0);
          hold_sender = 1'b1;
          while (in_valid || expected_atts.size() != 0) @(negedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end

    if (mismatches == 0) $display("calibration_table_interpolator_top: match");
    else $display("calibration_table_interpolator_top: mismatch");
    $finish;
  end
endmodule
